// ===== rtl/tdsm_pkg.sv =====
`timescale 1ns / 1ps

package tdsm_pkg;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SET   = 3'd1,
    CMD_START = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_EVENT = 3'd4,
    CMD_QUERY = 3'd5
  } command_e;

  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] RES_STATUS = 2'd0;
  localparam logic [1:0] RES_EXIT   = 2'd1;
  localparam logic [1:0] RES_ENTER  = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] state_kind;
    logic [7:0] enter_action;
    logic [7:0] exit_action;
    logic [3:0] from_state;
    logic [3:0] event_id;
    logic [3:0] target_state;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] action;
    logic       ok;
    logic [3:0] current_state;
    logic [3:0] new_index;
    logic       ended;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] enter_code;
    logic [7:0] exit_code;
  } state_rec_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] next;
  } trans_rec_t;

endpackage

// ===== rtl/tdsm_state_ram.sv =====
`timescale 1ns / 1ps

module tdsm_state_ram
  import tdsm_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  state_rec_t    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output state_rec_t    rdata_o
);

  state_rec_t mem [DEPTH];
  state_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tdsm_trans_ram.sv =====
`timescale 1ns / 1ps

module tdsm_trans_ram
  import tdsm_pkg::*;
#(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  trans_rec_t    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output trans_rec_t    rdata_o,
  output logic          clr_busy_o
);

  trans_rec_t    mem [DEPTH];
  trans_rec_t    rdata_q;
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  // After reset every entry is swept once so that all valid bits read as cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_q;

endmodule

// ===== rtl/table_driven_state_machine.sv =====
`timescale 1ns / 1ps

// Add state, set transition and unknown commands give one status beat.
// Start and stop scan the stored states one read per cycle.
// Query scans MAX_EVENTS transitions of the current state.
// An event gives up to three beats, one per cycle; results cannot stall, and busy drops
// in the cycle of the last beat. Reset is asynchronous; a clearing pass over all
// MAX_STATES * MAX_EVENTS transition entries keeps busy high.
module table_driven_state_machine
  import tdsm_pkg::*;
#(
  parameter int MAX_STATES = 16,
  parameter int MAX_EVENTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  cmd_item_t cmd_i,
  output logic      res_strobe_o,
  output result_t   res_o,
  input  logic      cfg_we_i,
  input  logic [4:0] cfg_wdata_i
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int EW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CW = $clog2(MAX_STATES + 1);
  localparam int EC = $clog2(MAX_EVENTS + 1);
  localparam int IW = (CW > EC) ? CW : EC;
  localparam int TD = MAX_STATES * MAX_EVENTS;
  localparam int AW = $clog2(TD);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_EV_T = 6'b001000,
    ST_EV_N = 6'b010000,
    ST_EMIT = 6'b100000
  } seq_state_e;

  function automatic logic [AW-1:0] trans_addr(input logic [SW-1:0] st,
                                               input logic [EW-1:0] ev);
    return AW'(AW'(st) * AW'(MAX_EVENTS)) + AW'(ev);
  endfunction

  seq_state_e    state_q, state_d;
  cmd_item_t     cmd_q;
  logic [CW-1:0] total_q, total_d;
  logic [SW-1:0] present_q, present_d;
  logic          finished_q, finished_d;
  logic [4:0]    evcnt_q;
  logic [IW-1:0] idx_q, idx_d, lim_q, lim_d, cmp_idx_q, cmp_idx_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic          st_ok_q, st_ok_d;
  logic [SW-1:0] next_q, next_d;
  logic [7:0]    xcode_q, xcode_d, ncode_q, ncode_d;
  logic          pend_x_q, pend_x_d, pend_n_q, pend_n_d;
  logic          strobe_q, strobe_d;
  result_t       res_q, res_d;

  logic          st_we;
  logic [SW-1:0] st_raddr;
  state_rec_t    st_wdata, st_rdata;
  logic          tr_we, tr_clr_busy;
  logic [AW-1:0] tr_waddr, tr_raddr;
  trans_rec_t    tr_wdata, tr_rdata;

  logic          emit, e_ok, e_last;
  logic [1:0]    e_kind;
  logic [7:0]    e_action, code;
  logic [3:0]    e_nidx;
  logic          match, is_query, set_ok;

  tdsm_state_ram #(.DEPTH(MAX_STATES)) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(SW'(total_q)),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  tdsm_trans_ram #(.DEPTH(TD)) u_trans_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (tr_we),
    .waddr_i   (tr_waddr),
    .wdata_i   (tr_wdata),
    .raddr_i   (tr_raddr),
    .rdata_o   (tr_rdata),
    .clr_busy_o(tr_clr_busy)
  );

  assign busy = (state_q != ST_IDLE) || tr_clr_busy;

  assign st_wdata = '{kind: cmd_q.state_kind, enter_code: cmd_q.enter_action,
                      exit_code: cmd_q.exit_action};
  assign tr_wdata = '{valid: 1'b1, next: cmd_q.target_state};
  assign tr_waddr = trans_addr(SW'(cmd_q.from_state), EW'(cmd_q.event_id));
  assign set_ok   = (32'(cmd_q.from_state) < MAX_STATES) &&
                    (32'(cmd_q.event_id) < MAX_EVENTS) &&
                    (32'(cmd_q.target_state) < MAX_STATES);
  assign is_query = (cmd_q.command == CMD_QUERY);

  // Shared scan comparator: state kinds for start and stop, transitions for a query.
  always_comb begin
    if (is_query) begin
      match = tr_rdata.valid && (tr_rdata.next == cmd_q.target_state);
    end else if (cmd_q.command == CMD_START) begin
      match = (st_rdata.kind == KIND_BEGIN);
    end else begin
      match = (st_rdata.kind == KIND_END);
    end
  end

  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    present_d  = present_q;
    finished_d = finished_q;
    idx_d      = idx_q;
    lim_d      = lim_q;
    cmp_idx_d  = cmp_idx_q;
    cmp_vld_d  = cmp_vld_q;
    st_ok_d    = st_ok_q;
    next_d     = next_q;
    xcode_d    = xcode_q;
    ncode_d    = ncode_q;
    pend_x_d   = pend_x_q;
    pend_n_d   = pend_n_q;
    st_we      = 1'b0;
    tr_we      = 1'b0;
    st_raddr   = SW'(idx_q);
    tr_raddr   = trans_addr(present_q, EW'(idx_q));
    emit       = 1'b0;
    e_kind     = RES_STATUS;
    e_action   = '0;
    e_ok       = 1'b0;
    e_nidx     = '0;
    e_last     = 1'b1;
    code       = '0;

    case (state_q)
      ST_IDLE: begin
        if (start && !tr_clr_busy) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (cmd_q.command)
          CMD_ADD: begin
            emit = 1'b1;
            if (32'(total_q) < MAX_STATES) begin
              st_we   = 1'b1;
              total_d = total_q + CW'(1);
              e_ok    = 1'b1;
              e_nidx  = 4'(total_q);
            end
          end
          CMD_SET: begin
            emit  = 1'b1;
            tr_we = set_ok;
            e_ok  = set_ok;
          end
          CMD_START, CMD_STOP, CMD_QUERY: begin
            state_d   = ST_SCAN;
            idx_d     = '0;
            cmp_vld_d = 1'b0;
            lim_d     = is_query ? IW'(MAX_EVENTS) : IW'(total_q);
          end
          CMD_EVENT: begin
            if (finished_q || ({1'b0, cmd_q.event_id} >= evcnt_q) ||
                (32'(cmd_q.event_id) >= MAX_EVENTS)) begin
              emit = 1'b1;
            end else begin
              state_d  = ST_EV_T;
              st_raddr = present_q;
              tr_raddr = trans_addr(present_q, EW'(cmd_q.event_id));
              st_ok_d  = (32'(present_q) < 32'(total_q));
            end
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      ST_SCAN: begin
        if (idx_q < lim_q) begin
          idx_d     = idx_q + IW'(1);
          cmp_idx_d = idx_q;
          cmp_vld_d = 1'b1;
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q && match) begin
          emit    = 1'b1;
          e_ok    = 1'b1;
          state_d = ST_IDLE;
          if (!is_query) begin
            present_d  = SW'(cmp_idx_q);
            finished_d = (cmd_q.command == CMD_STOP);
          end
        end else if (!cmp_vld_q && !(idx_q < lim_q)) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_EV_T: begin
        xcode_d = st_ok_q ? st_rdata.exit_code : 8'd0;
        if (!tr_rdata.valid) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          next_d   = SW'(tr_rdata.next);
          st_raddr = SW'(tr_rdata.next);
          st_ok_d  = (32'(tr_rdata.next) < 32'(total_q));
          state_d  = ST_EV_N;
        end
      end
      ST_EV_N: begin
        code      = st_ok_q ? st_rdata.enter_code : 8'd0;
        ncode_d   = code;
        present_d = next_q;
        if (st_ok_q && (st_rdata.kind == KIND_END)) begin
          finished_d = 1'b1;
        end
        pend_x_d = (xcode_q != 8'd0);
        pend_n_d = (code != 8'd0);
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        emit = 1'b1;
        if (pend_x_q) begin
          pend_x_d = 1'b0;
          e_kind   = RES_EXIT;
          e_action = xcode_q;
          e_ok     = 1'b1;
          e_last   = 1'b0;
        end else if (pend_n_q) begin
          pend_n_d = 1'b0;
          e_kind   = RES_ENTER;
          e_action = ncode_q;
          e_ok     = 1'b1;
          e_last   = 1'b0;
        end else begin
          e_ok    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    strobe_d = emit;
    res_d    = res_q;
    if (emit) begin
      res_d = '{kind: e_kind, action: e_action, ok: e_ok,
                current_state: 4'(present_d), new_index: e_nidx,
                ended: finished_d, last: e_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      total_q    <= '0;
      present_q  <= '0;
      finished_q <= 1'b0;
      evcnt_q    <= '0;
      idx_q      <= '0;
      lim_q      <= '0;
      cmp_vld_q  <= 1'b0;
      st_ok_q    <= 1'b0;
      pend_x_q   <= 1'b0;
      pend_n_q   <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      total_q    <= total_d;
      present_q  <= present_d;
      finished_q <= finished_d;
      idx_q      <= idx_d;
      lim_q      <= lim_d;
      cmp_vld_q  <= cmp_vld_d;
      st_ok_q    <= st_ok_d;
      pend_x_q   <= pend_x_d;
      pend_n_q   <= pend_n_d;
      strobe_q   <= strobe_d;
      if (cfg_we_i) begin
        evcnt_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start && !tr_clr_busy) begin
      cmd_q <= cmd_i;
    end
    cmp_idx_q <= cmp_idx_d;
    next_q    <= next_d;
    xcode_q   <= xcode_d;
    ncode_q   <= ncode_d;
    res_q     <= res_d;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule
